FILE: sv/ead_pkg.sv
`timescale 1ns / 1ps

package ead_pkg;

  localparam int POSITION_WIDTH_DEF        = 48;
  localparam int DENSITY_FRACTION_BITS_DEF = 32;

  localparam int MAG_W      = 34;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int H_W        = 20;
  localparam int RADIUS_W   = 32;
  localparam int AM_W       = H_W + 6;
  localparam int LOG2E_W    = 33;
  localparam int PROD_W     = AM_W + LOG2E_W;
  localparam int XQ_W       = PROD_W - H_W;
  localparam int FRAC_W     = 32;
  localparam int N_W        = 9;
  localparam int M_W        = FRAC_W + 1;
  localparam int TEMP_W     = 9;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 64;
  localparam int SQRT_STEPS = 2;
  localparam int DIV_STEPS  = 3;

  localparam logic [LOG2E_W-1:0]    LOG2E_Q32        = 33'd6196328019;
  localparam logic [TEMP_W-1:0]     TEMPERATURE_K    = 9'd300;
  localparam logic [63:0]           BASE_DENSITY_RST = 64'd5226975199;
  localparam logic [H_W-1:0]        SCALE_HEIGHT_RST = 20'd8500;
  localparam logic [RADIUS_W-1:0]   PLANET_RADIUS_RST = 32'd6371008;

  localparam logic [CFG_ADDR_W-1:0] CFG_BASE_DENSITY  = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_HEIGHT  = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PLANET_RADIUS = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_ENABLE  = 8'd3;

  // How the final density is formed.
  localparam logic [1:0] MODE_CALC = 2'd0;
  localparam logic [1:0] MODE_ZERO = 2'd1;
  localparam logic [1:0] MODE_SAT  = 2'd2;

  typedef logic [M_W-1:0] root_tab_t [FRAC_W];

  function automatic logic [63:0] isqrt128(input logic [127:0] x);
    logic [63:0]  res;
    logic [63:0]  c;
    logic [127:0] sq;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      c  = res | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= x) res = c;
    end
    return res;
  endfunction

  // Entry k is 2^(2^-(k+1)) in Q32, each one the root of the one before.
  function automatic root_tab_t build_root_tab();
    root_tab_t    tab;
    logic [127:0] x;
    x      = {64'd2, 64'd0};
    tab[0] = M_W'(isqrt128(x));
    for (int k = 1; k < FRAC_W; k++) begin
      x      = {64'd0, 64'(tab[k-1])} << 32;
      tab[k] = M_W'(isqrt128(x));
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_TAB = build_root_tab();

endpackage

FILE: sv/ead_in_if.sv
`timescale 1ns / 1ps

interface ead_in_if #(
  parameter int PW = ead_pkg::POSITION_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [PW-1:0] craft_x;
  logic signed [PW-1:0] craft_y;
  logic signed [PW-1:0] craft_z;
  logic signed [PW-1:0] body_x;
  logic signed [PW-1:0] body_y;
  logic signed [PW-1:0] body_z;

  modport source (output valid, craft_x, craft_y, craft_z, body_x, body_y, body_z,
                  input ready);
  modport sink (input valid, craft_x, craft_y, craft_z, body_x, body_y, body_z,
                output ready);
endinterface

FILE: sv/ead_out_if.sv
`timescale 1ns / 1ps

interface ead_out_if #(
  parameter int DW = 16 + ead_pkg::DENSITY_FRACTION_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic [DW-1:0]               density;
  logic                        density_saturated;
  logic [ead_pkg::TEMP_W-1:0]  temperature_k;

  modport source (output valid, density, density_saturated, temperature_k, input ready);
  modport sink (input valid, density, density_saturated, temperature_k, output ready);
endinterface

FILE: sv/ead_cfg_if.sv
`timescale 1ns / 1ps

interface ead_cfg_if ();
  logic                            valid;
  logic                            ready;
  logic [ead_pkg::CFG_ADDR_W-1:0]  addr;
  logic [ead_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

FILE: sv/ead_isqrt.sv
`timescale 1ns / 1ps

module ead_isqrt #(
  parameter int IN_W   = ead_pkg::SUM_W,
  parameter int OUT_W  = ead_pkg::ROOT_W,
  parameter int SIDE_W = 1,
  parameter int STEPS  = ead_pkg::SQRT_STEPS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   in_x,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [OUT_W-1:0]  out_root,
  output logic [SIDE_W-1:0] out_side
);
  localparam int NS    = (OUT_W + STEPS - 1) / STEPS;
  localparam int REM_W = OUT_W + 3;

  logic [NS-1:0]     v_r;
  logic [IN_W-1:0]   x_r    [NS];
  logic [REM_W-1:0]  rem_r  [NS];
  logic [OUT_W-1:0]  root_r [NS];
  logic [SIDE_W-1:0] side_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic              v_in;
    logic [IN_W-1:0]   x_in, x_nxt;
    logic [REM_W-1:0]  rem_in, rem_nxt;
    logic [OUT_W-1:0]  root_in, root_nxt;
    logic [SIDE_W-1:0] side_in;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign x_in    = in_x;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[s-1];
      assign x_in    = x_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign side_in = side_r[s-1];
    end

    // Restoring square root, one result bit per step from two input bits.
    always_comb begin
      logic [REM_W-1:0] t;
      logic [REM_W-1:0] trial;
      t        = '0;
      trial    = '0;
      x_nxt    = x_in;
      rem_nxt  = rem_in;
      root_nxt = root_in;
      for (int j = 0; j < STEPS; j++) begin
        if (s * STEPS + j < OUT_W) begin
          t     = {rem_nxt[REM_W-3:0], x_nxt[IN_W-1 -: 2]};
          trial = {1'b0, root_nxt, 2'b01};
          if (t >= trial) begin
            rem_nxt  = t - trial;
            root_nxt = {root_nxt[OUT_W-2:0], 1'b1};
          end else begin
            rem_nxt  = t;
            root_nxt = {root_nxt[OUT_W-2:0], 1'b0};
          end
          x_nxt = x_nxt << 2;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[s]    <= x_nxt;
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
        side_r[s] <= side_in;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_side  = side_r[NS-1];
endmodule

FILE: sv/ead_div.sv
`timescale 1ns / 1ps

module ead_div #(
  parameter int NUM_W  = ead_pkg::PROD_W,
  parameter int DEN_W  = ead_pkg::H_W,
  parameter int Q_W    = ead_pkg::XQ_W,
  parameter int SIDE_W = 3,
  parameter int STEPS  = ead_pkg::DIV_STEPS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [DEN_W-1:0]  den,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_q,
  output logic [SIDE_W-1:0] out_side
);
  localparam int NS = (Q_W + STEPS - 1) / STEPS;

  logic [NS-1:0]     v_r;
  logic [Q_W-1:0]    x_r    [NS];
  logic [DEN_W-1:0]  rem_r  [NS];
  logic [Q_W-1:0]    q_r    [NS];
  logic [SIDE_W-1:0] side_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic              v_in;
    logic [Q_W-1:0]    x_in, x_nxt;
    logic [DEN_W-1:0]  rem_in, rem_nxt;
    logic [Q_W-1:0]    q_in, q_nxt;
    logic [SIDE_W-1:0] side_in;

    // The quotient is known to fit Q_W bits, so the bits above start the remainder.
    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign x_in    = in_num[Q_W-1:0];
      assign rem_in  = DEN_W'(in_num >> Q_W);
      assign q_in    = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[s-1];
      assign x_in    = x_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign q_in    = q_r[s-1];
      assign side_in = side_r[s-1];
    end

    always_comb begin
      logic [DEN_W:0] t;
      t       = '0;
      x_nxt   = x_in;
      rem_nxt = rem_in;
      q_nxt   = q_in;
      for (int j = 0; j < STEPS; j++) begin
        if (s * STEPS + j < Q_W) begin
          t = {rem_nxt, x_nxt[Q_W-1]};
          if (t >= {1'b0, den}) begin
            rem_nxt = DEN_W'(t - {1'b0, den});
            q_nxt   = {q_nxt[Q_W-2:0], 1'b1};
          end else begin
            rem_nxt = t[DEN_W-1:0];
            q_nxt   = {q_nxt[Q_W-2:0], 1'b0};
          end
          x_nxt = x_nxt << 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[s]    <= x_nxt;
        rem_r[s]  <= rem_nxt;
        q_r[s]    <= q_nxt;
        side_r[s] <= side_in;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_q     = q_r[NS-1];
  assign out_side  = side_r[NS-1];
endmodule

FILE: sv/ead_pow2.sv
`timescale 1ns / 1ps

module ead_pow2 #(
  parameter int SIDE_W = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [ead_pkg::FRAC_W-1:0] in_f,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [ead_pkg::M_W-1:0]    out_m,
  output logic [SIDE_W-1:0]          out_side
);
  localparam int NS  = ead_pkg::FRAC_W;
  localparam int MW  = ead_pkg::M_W;
  localparam int FW  = ead_pkg::FRAC_W;

  logic [NS-1:0]     v_r;
  logic [FW-1:0]     f_r    [NS];
  logic [MW-1:0]     acc_r  [NS];
  logic [SIDE_W-1:0] side_r [NS];

  // One factor of the table per stage, applied when its fraction bit is set.
  for (genvar k = 0; k < NS; k++) begin : g_st
    logic              v_in;
    logic [FW-1:0]     f_in;
    logic [MW-1:0]     acc_in, acc_nxt;
    logic [SIDE_W-1:0] side_in;
    logic [2*MW-1:0]   prod;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign f_in    = in_f;
      assign acc_in  = MW'(1) << FW;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign f_in    = f_r[k-1];
      assign acc_in  = acc_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign prod    = (2*MW)'(acc_in) * (2*MW)'(ead_pkg::ROOT_TAB[k]);
    assign acc_nxt = f_in[FW-1-k] ? MW'(prod >> FW) : acc_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        f_r[k]    <= f_in;
        acc_r[k]  <= acc_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_m     = acc_r[NS-1];
  assign out_side  = side_r[NS-1];
endmodule

FILE: sv/exponential_atmosphere_density.sv
`timescale 1ns / 1ps

// Exponential atmosphere density.
// in_ch carries one spacecraft position and one planet centre position per item;
// out_ch returns one result per item: density = base * exp(-altitude / scale
// height) in the base density's format, a saturation flag, and 300 K.
// cfg_ch writes the registers: 0 base density, 1 scale height, 2 planet radius,
// 3 planet frame enable. It is always ready; write only while the block is idle.
// Throughput is one item per cycle while out_ch takes each result. Pipeline depth
// is set by the stages of the square root (two bits per stage), the divider (three
// quotient bits per stage) and the 32 table multiplies of the fractional power of two,
// one per stage.
// The pipeline advances as a whole: when out_ch holds an item that is not taken,
// every stage holds and in_ch.ready falls in the same cycle, so nothing is lost.
// Synchronous reset clears all valid bits and loads the register reset values.
module exponential_atmosphere_density #(
  parameter int POSITION_WIDTH        = ead_pkg::POSITION_WIDTH_DEF,
  parameter int DENSITY_FRACTION_BITS = ead_pkg::DENSITY_FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ead_in_if.sink    in_ch,
  ead_out_if.source out_ch,
  ead_cfg_if.sink   cfg_ch
);
  localparam int PW    = POSITION_WIDTH;
  localparam int DW    = 16 + DENSITY_FRACTION_BITS;
  localparam int MAG_W = ead_pkg::MAG_W;
  localparam int SQ_W  = ead_pkg::SQ_W;
  localparam int SUM_W = ead_pkg::SUM_W;
  localparam int RT_W  = ead_pkg::ROOT_W;
  localparam int H_W   = ead_pkg::H_W;
  localparam int R_W   = ead_pkg::RADIUS_W;
  localparam int AM_W  = ead_pkg::AM_W;
  localparam int PR_W  = ead_pkg::PROD_W;
  localparam int XQ_W  = ead_pkg::XQ_W;
  localparam int FW    = ead_pkg::FRAC_W;
  localparam int N_W   = ead_pkg::N_W;
  localparam int M_W   = ead_pkg::M_W;
  localparam int LO_W  = DW / 2;
  localparam int HI_W  = DW - LO_W;
  localparam int PWD   = DW + M_W;
  localparam int EXTW  = PWD + FW;
  localparam int A_W   = RT_W + 2;

  // Configuration registers.
  logic [DW-1:0]  base_r;
  logic [H_W-1:0] height_r;
  logic [R_W-1:0] radius_r;
  logic           frame_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= DW'(ead_pkg::BASE_DENSITY_RST);
      height_r <= ead_pkg::SCALE_HEIGHT_RST;
      radius_r <= ead_pkg::PLANET_RADIUS_RST;
      frame_r  <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        ead_pkg::CFG_BASE_DENSITY:  base_r   <= cfg_ch.data[DW-1:0];
        ead_pkg::CFG_SCALE_HEIGHT:  height_r <= cfg_ch.data[H_W-1:0];
        ead_pkg::CFG_PLANET_RADIUS: radius_r <= cfg_ch.data[R_W-1:0];
        ead_pkg::CFG_FRAME_ENABLE:  frame_r  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  logic [H_W-1:0] h_eff;
  assign h_eff = (height_r == '0) ? H_W'(1) : height_r;

  logic en;
  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: component magnitudes.
  logic signed [PW-1:0] craft [3];
  logic signed [PW-1:0] body  [3];
  logic [MAG_W-1:0]     mag_nxt [3];
  logic                 kill1_nxt;
  logic                 v1_r, kill1_r;
  logic [MAG_W-1:0]     mag1_r [3];

  assign craft[0] = in_ch.craft_x;
  assign craft[1] = in_ch.craft_y;
  assign craft[2] = in_ch.craft_z;
  assign body[0]  = in_ch.body_x;
  assign body[1]  = in_ch.body_y;
  assign body[2]  = in_ch.body_z;

  always_comb begin
    logic signed [PW:0] diff;
    logic [PW:0]        absd;
    diff      = '0;
    absd      = '0;
    kill1_nxt = (base_r == '0);
    for (int i = 0; i < 3; i++) begin
      diff = (PW+1)'(craft[i]) - (frame_r ? (PW+1)'(body[i]) : '0);
      absd = diff[PW] ? (PW+1)'(-diff) : (PW+1)'(diff);
      mag_nxt[i] = MAG_W'(absd);
      if ((absd >> MAG_W) != '0) kill1_nxt = 1'b1;
    end
  end

  // Stage 2: squares. Stage 3: sum.
  logic            v2_r, kill2_r;
  logic [SQ_W-1:0] sq2_r [3];
  logic             v3_r, kill3_r;
  logic [SUM_W-1:0] sum3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kill1_r <= kill1_nxt;
      for (int i = 0; i < 3; i++) begin
        mag1_r[i] <= mag_nxt[i];
        sq2_r[i]  <= SQ_W'(mag1_r[i]) * SQ_W'(mag1_r[i]);
      end
      kill2_r <= kill1_r;
      sum3_r  <= SUM_W'(sq2_r[0]) + SUM_W'(sq2_r[1]) + SUM_W'(sq2_r[2]);
      kill3_r <= kill2_r;
    end
  end

  // Norm.
  logic            v4, kill4;
  logic [RT_W-1:0] root4;

  ead_isqrt #(
    .IN_W(SUM_W), .OUT_W(RT_W), .SIDE_W(1), .STEPS(ead_pkg::SQRT_STEPS)
  ) u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v3_r), .in_x(sum3_r), .in_side(kill3_r),
    .out_valid(v4), .out_root(root4), .out_side(kill4)
  );

  // Stage 5: altitude and range checks.
  logic signed [A_W-1:0] alt;
  logic [A_W-2:0]        am_abs;
  logic                  decay_nxt;
  logic [AM_W-1:0]       lim64, lim40;
  logic [1:0]            mode5_nxt;
  logic                  v5_r, decay5_r;
  logic [AM_W-1:0]       am5_r;
  logic [1:0]            mode5_r;

  assign alt       = $signed({2'b00, root4}) - $signed({(A_W-R_W)'(0), radius_r});
  assign decay_nxt = !alt[A_W-1];
  assign am_abs    = decay_nxt ? (A_W-1)'(alt) : (A_W-1)'(-alt);
  assign lim64     = {h_eff, 6'b0};
  assign lim40     = AM_W'({h_eff, 5'b0}) + AM_W'({h_eff, 3'b0});

  always_comb begin
    if (kill4) begin
      mode5_nxt = ead_pkg::MODE_ZERO;
    end else if (decay_nxt && am_abs >= (A_W-1)'(lim64)) begin
      mode5_nxt = ead_pkg::MODE_ZERO;
    end else if (!decay_nxt && am_abs >= (A_W-1)'(lim40)) begin
      mode5_nxt = ead_pkg::MODE_SAT;
    end else begin
      mode5_nxt = ead_pkg::MODE_CALC;
    end
  end

  // Stage 6: |a| * log2(e).
  logic            v6_r, decay6_r;
  logic [PR_W-1:0] prod6_r;
  logic [1:0]      mode6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am5_r    <= AM_W'(am_abs);
      decay5_r <= decay_nxt;
      mode5_r  <= mode5_nxt;
      prod6_r  <= PR_W'(am5_r) * PR_W'(ead_pkg::LOG2E_Q32);
      decay6_r <= decay5_r;
      mode6_r  <= mode5_r;
    end
  end

  // Exponent in Q32 after division by the scale height.
  logic            v7;
  logic [XQ_W-1:0] xq7;
  logic [2:0]      side7;

  ead_div #(
    .NUM_W(PR_W), .DEN_W(H_W), .Q_W(XQ_W), .SIDE_W(3), .STEPS(ead_pkg::DIV_STEPS)
  ) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .den(h_eff),
    .in_valid(v6_r), .in_num(prod6_r), .in_side({mode6_r, decay6_r}),
    .out_valid(v7), .out_q(xq7), .out_side(side7)
  );

  // Stage 8: split into integer power n and fraction f, with 0 <= f < 1.
  logic [XQ_W-FW-1:0]  ip7;
  logic [FW-1:0]       fp7;
  logic signed [N_W-1:0] n8_nxt;
  logic                v8_r;
  logic [FW-1:0]       f8_r;
  logic signed [N_W-1:0] n8_r;
  logic [1:0]          mode8_r;

  assign ip7 = xq7[XQ_W-1:FW];
  assign fp7 = xq7[FW-1:0];

  always_comb begin
    if (!side7[0]) begin
      n8_nxt = $signed(N_W'(ip7));
    end else if (fp7 == '0) begin
      n8_nxt = -$signed(N_W'(ip7));
    end else begin
      n8_nxt = -$signed(N_W'(ip7) + N_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f8_r    <= side7[0] ? FW'(-fp7) : fp7;
      n8_r    <= n8_nxt;
      mode8_r <= side7[2:1];
    end
  end

  // 2^f in Q32.
  logic                 v9;
  logic [M_W-1:0]       m9;
  logic [N_W+1:0]       side9;

  ead_pow2 #(
    .SIDE_W(N_W + 2)
  ) u_pow2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v8_r), .in_f(f8_r), .in_side({n8_r, mode8_r}),
    .out_valid(v9), .out_m(m9), .out_side(side9)
  );

  // Stage 10: partial products of base * m. Stage 11: their sum.
  logic                  v10_r, v11_r;
  logic [LO_W+M_W-1:0]   pl10_r;
  logic [HI_W+M_W-1:0]   ph10_r;
  logic signed [N_W-1:0] n10_r, n11_r;
  logic [1:0]            mode10_r, mode11_r;
  logic [PWD-1:0]        p11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
      v11_r <= 1'b0;
    end else if (en) begin
      v10_r <= v9;
      v11_r <= v10_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl10_r   <= (LO_W+M_W)'(base_r[LO_W-1:0]) * (LO_W+M_W)'(m9);
      ph10_r   <= (HI_W+M_W)'(base_r[DW-1:LO_W]) * (HI_W+M_W)'(m9);
      n10_r    <= side9[N_W+1:2];
      mode10_r <= side9[1:0];
      p11_r    <= (PWD'(ph10_r) << LO_W) + PWD'(pl10_r);
      n11_r    <= n10_r;
      mode11_r <= mode10_r;
    end
  end

  // Stage 12: scale by 2^(n-32), saturate, and hold for the receiver.
  logic signed [N_W:0] shift_s;
  logic [N_W:0]        shift_r;
  logic [EXTW-1:0]     scaled;
  logic [DW-1:0]       dens_nxt;
  logic                sat_nxt;
  logic [DW-1:0]       density_r;
  logic                sat_r;

  assign shift_s = $signed({n11_r[N_W-1], n11_r}) - $signed((N_W+1)'(FW));
  assign shift_r = (N_W+1)'(-shift_s);
  assign scaled  = shift_s[N_W] ? (EXTW'(p11_r) >> shift_r)
                                : (EXTW'(p11_r) << shift_s[N_W-1:0]);

  always_comb begin
    case (mode11_r)
      ead_pkg::MODE_ZERO: begin
        dens_nxt = '0;
        sat_nxt  = 1'b0;
      end
      ead_pkg::MODE_SAT: begin
        dens_nxt = '1;
        sat_nxt  = 1'b1;
      end
      default: begin
        if ((scaled >> DW) != '0) begin
          dens_nxt = '1;
          sat_nxt  = 1'b1;
        end else begin
          dens_nxt = DW'(scaled);
          sat_nxt  = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v11_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      density_r <= dens_nxt;
      sat_r     <= sat_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.density           = density_r;
  assign out_ch.density_saturated = sat_r;
  assign out_ch.temperature_k     = ead_pkg::TEMPERATURE_K;
endmodule
